// ===== design/gbn_pkg.sv =====
// gbn_pkg: shared types, constants and helpers for the go-back-n endpoint
// no dependencies; used by gbn_front, gbn_queue, gbn_back and the top level

package gbn_pkg;

  localparam int SeqBits      = 3;
  localparam int SeqMod       = 1 << SeqBits;
  localparam int MaxSeq       = SeqMod - 1;
  localparam int PayloadWidth = 32;
  localparam int TimerWidth   = 16;
  localparam int QueueDepth   = 2;   // power of two, pointers wrap naturally
  localparam int QPtrBits     = $clog2(QueueDepth);

  typedef logic [SeqBits-1:0]      seq_t;
  typedef logic [PayloadWidth-1:0] payload_t;
  typedef logic [TimerWidth-1:0]   timer_t;

  localparam timer_t TimeoutReset = TimerWidth'(10000);
  localparam timer_t TimerMax     = {TimerWidth{1'b1}};
  localparam seq_t   MaxSeqVal    = SeqBits'(MaxSeq);

  // input operation codes
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t      kind;
    payload_t payload;
    seq_t     fseq;
    seq_t     fack;
    logic     is_data;
  } cmd_t;

  // true when b lies in the circular range [a, c)
  function automatic logic in_window(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

// ===== design/gbn_front.sv =====
// gbn_front: takes input transactions and classifies them into commands
// depends on gbn_pkg

module gbn_front (
  input  logic              start,
  input  logic              q_full,
  input  logic [1:0]        in_op,
  input  gbn_pkg::payload_t in_payload,
  input  gbn_pkg::seq_t     in_frame_seq,
  input  gbn_pkg::seq_t     in_frame_ack,
  input  logic              in_frame_is_data,
  output logic              push,
  output gbn_pkg::cmd_t     push_cmd
);

  logic known_op;

  always_comb begin
    unique case (in_op)
      gbn_pkg::OP_SEND, gbn_pkg::OP_RECV, gbn_pkg::OP_TICK: known_op = 1'b1;
      default:                                              known_op = 1'b0;
    endcase
  end

  // unused op codes are swallowed here, they never produce a result
  assign push = start && !q_full && known_op;

  always_comb begin
    push_cmd.kind    = gbn_pkg::op_t'(in_op);
    push_cmd.payload = in_payload;
    push_cmd.fseq    = in_frame_seq;
    push_cmd.fack    = in_frame_ack;
    push_cmd.is_data = in_frame_is_data;
  end

endmodule

// ===== design/gbn_queue.sv =====
// gbn_queue: short command queue between front and back
// depends on gbn_pkg

module gbn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gbn_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output gbn_pkg::cmd_t head
);

  gbn_pkg::cmd_t                  entries_r [gbn_pkg::QueueDepth];
  logic [gbn_pkg::QPtrBits-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [gbn_pkg::QPtrBits-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [gbn_pkg::QPtrBits:0]     fill_r, fill_nxt;

  assign full  = (fill_r == (gbn_pkg::QPtrBits+1)'(gbn_pkg::QueueDepth));
  assign valid = (fill_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (gbn_pkg::QPtrBits+1)'(push) - (gbn_pkg::QPtrBits+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/gbn_back.sv =====
// gbn_back: executes commands, holds the window state and emits results
// depends on gbn_pkg

module gbn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gbn_pkg::timer_t     timeout,
  input  logic                q_valid,
  input  gbn_pkg::cmd_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output gbn_pkg::seq_t       out_seq,
  output gbn_pkg::seq_t       out_ack,
  output gbn_pkg::payload_t   out_payload,
  output logic                out_last
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEND   = 7'b0000010,
    ST_DLV    = 7'b0000100,
    ST_ACK    = 7'b0001000,
    ST_REL    = 7'b0010000,
    ST_TICK   = 7'b0100000,
    ST_RESEND = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  gbn_pkg::cmd_t         cmd_r, cmd_nxt;
  gbn_pkg::seq_t         next_r, next_nxt;
  gbn_pkg::seq_t         oldest_r, oldest_nxt;
  gbn_pkg::seq_t         count_r, count_nxt;
  gbn_pkg::seq_t         exp_r, exp_nxt;
  gbn_pkg::seq_t         ptr_r, ptr_nxt;
  gbn_pkg::seq_t         rem_r, rem_nxt;
  gbn_pkg::timer_t       timers_r [gbn_pkg::SeqMod];
  gbn_pkg::timer_t       timers_nxt [gbn_pkg::SeqMod];
  logic [gbn_pkg::SeqMod-1:0] running_r, running_nxt;
  gbn_pkg::payload_t     window_r [gbn_pkg::SeqMod];
  logic                  win_we;
  logic                  win_re;

  logic                  ov_r, ov_nxt;
  gbn_pkg::kind_t        okind_r, okind_nxt;
  gbn_pkg::seq_t         oseq_r, oseq_nxt;
  gbn_pkg::seq_t         oack_r, oack_nxt;
  gbn_pkg::payload_t     opay_r, opay_nxt;
  logic                  olast_r, olast_nxt;

  gbn_pkg::seq_t         piggy;

  // ack piggybacked on data frames: last frame taken in order
  assign piggy = gbn_pkg::seq_t'(exp_r - 1'b1);

  always_comb begin
    gbn_pkg::timer_t t;
    logic expired;

    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    next_nxt    = next_r;
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    exp_nxt     = exp_r;
    ptr_nxt     = ptr_r;
    rem_nxt     = rem_r;
    timers_nxt  = timers_r;
    running_nxt = running_r;
    win_we      = 1'b0;
    win_re      = 1'b0;
    q_pop       = 1'b0;
    ov_nxt      = 1'b0;
    okind_nxt   = gbn_pkg::KIND_DATA;
    oseq_nxt    = '0;
    oack_nxt    = '0;
    opay_nxt    = '0;
    olast_nxt   = 1'b0;
    t           = '0;
    expired     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          unique case (q_head.kind)
            gbn_pkg::OP_SEND: state_nxt = ST_SEND;
            gbn_pkg::OP_RECV: begin
              if (q_head.is_data && (q_head.fseq == exp_r)) begin
                state_nxt = ST_DLV;
              end else begin
                state_nxt = ST_REL;
              end
            end
            gbn_pkg::OP_TICK: state_nxt = ST_TICK;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SEND: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (count_r == gbn_pkg::MaxSeqVal) begin
          okind_nxt = gbn_pkg::KIND_REFUSED;
        end else begin
          okind_nxt           = gbn_pkg::KIND_DATA;
          oseq_nxt            = next_r;
          oack_nxt            = piggy;
          opay_nxt            = cmd_r.payload;
          win_we              = 1'b1;
          timers_nxt[next_r]  = '0;
          running_nxt[next_r] = 1'b1;
          count_nxt           = gbn_pkg::seq_t'(count_r + 1'b1);
          next_nxt            = gbn_pkg::seq_t'(next_r + 1'b1);
        end
        state_nxt = ST_IDLE;
      end

      ST_DLV: begin
        ov_nxt    = 1'b1;
        okind_nxt = gbn_pkg::KIND_DELIVER;
        opay_nxt  = cmd_r.payload;
        state_nxt = ST_ACK;
      end

      ST_ACK: begin
        ov_nxt    = 1'b1;
        okind_nxt = gbn_pkg::KIND_ACK;
        oack_nxt  = exp_r;
        olast_nxt = 1'b1;
        exp_nxt   = gbn_pkg::seq_t'(exp_r + 1'b1);
        state_nxt = ST_REL;
      end

      // cumulative release, one slot a cycle
      ST_REL: begin
        if ((count_r != '0) && gbn_pkg::in_window(oldest_r, cmd_r.fack, next_r)) begin
          running_nxt[oldest_r] = 1'b0;
          timers_nxt[oldest_r]  = '0;
          count_nxt             = gbn_pkg::seq_t'(count_r - 1'b1);
          oldest_nxt            = gbn_pkg::seq_t'(oldest_r + 1'b1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_TICK: begin
        for (int i = 0; i < gbn_pkg::SeqMod; i++) begin
          if (running_r[i]) begin
            t = timers_r[i];
            if (t != gbn_pkg::TimerMax) begin
              t = gbn_pkg::timer_t'(t + 1'b1);
            end
            timers_nxt[i] = t;
            if (t >= timeout) begin
              expired = 1'b1;
            end
          end
        end
        if (expired && (count_r != '0)) begin
          ptr_nxt   = oldest_r;
          rem_nxt   = count_r;
          state_nxt = ST_RESEND;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // resend the whole window, oldest first; payload read from the window
      ST_RESEND: begin
        ov_nxt             = 1'b1;
        okind_nxt          = gbn_pkg::KIND_DATA;
        oseq_nxt           = ptr_r;
        oack_nxt           = piggy;
        win_re             = 1'b1;
        olast_nxt          = (rem_r == gbn_pkg::seq_t'(1));
        timers_nxt[ptr_r]  = '0;
        running_nxt[ptr_r] = 1'b1;
        ptr_nxt            = gbn_pkg::seq_t'(ptr_r + 1'b1);
        rem_nxt            = gbn_pkg::seq_t'(rem_r - 1'b1);
        if (rem_r == gbn_pkg::seq_t'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      next_r    <= '0;
      oldest_r  <= '0;
      count_r   <= '0;
      exp_r     <= '0;
      ptr_r     <= '0;
      rem_r     <= '0;
      running_r <= '0;
      ov_r      <= 1'b0;
      for (int i = 0; i < gbn_pkg::SeqMod; i++) begin
        timers_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      next_r    <= next_nxt;
      oldest_r  <= oldest_nxt;
      count_r   <= count_nxt;
      exp_r     <= exp_nxt;
      ptr_r     <= ptr_nxt;
      rem_r     <= rem_nxt;
      running_r <= running_nxt;
      ov_r      <= ov_nxt;
      timers_r  <= timers_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    okind_r <= okind_nxt;
    oseq_r  <= oseq_nxt;
    oack_r  <= oack_nxt;
    olast_r <= olast_nxt;
    if (win_re) begin
      opay_r <= window_r[ptr_r];
    end else begin
      opay_r <= opay_nxt;
    end
    if (win_we) begin
      window_r[next_r] <= cmd_r.payload;
    end
  end

  assign out_valid   = ov_r;
  assign out_kind    = okind_r;
  assign out_seq     = oseq_r;
  assign out_ack     = oack_r;
  assign out_payload = opay_r;
  assign out_last    = olast_r;

endmodule

// ===== design/go_back_n_arq_endpoint.sv =====
// go_back_n_arq_endpoint: top level of the sliding-window arq endpoint
// depends on gbn_pkg, gbn_front, gbn_queue and gbn_back
//
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | start / busy         | in_op, in_payload, in_frame_seq,
//           |                      | in_frame_ack, in_frame_is_data
// result    | out_valid strobe     | out_kind, out_seq, out_ack, out_payload,
//           |                      | out_last
// config    | cfg_we               | cfg_wdata (timeout in ticks)
//
// a transaction is taken when start is high and busy low; busy rises only
// when the two-entry command queue is full
// in the back end a send is handled in the send state; a received frame passes
// through delivery and ack when it is in-order data and then a release walk that
// frees one slot a cycle; a tick updates the timers and, on expiry, resends the window
// results leave a register one per cycle with a single-cycle strobe and
// cannot be held off; out_last marks the final result of a transaction
// reset is synchronous and active low; it empties the window, stops all
// timers and loads the default timeout of 10000 ticks

module go_back_n_arq_endpoint (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  gbn_pkg::payload_t    in_payload,
  input  gbn_pkg::seq_t        in_frame_seq,
  input  gbn_pkg::seq_t        in_frame_ack,
  input  logic                 in_frame_is_data,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output gbn_pkg::seq_t        out_seq,
  output gbn_pkg::seq_t        out_ack,
  output gbn_pkg::payload_t    out_payload,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  gbn_pkg::timer_t      cfg_wdata
);

  gbn_pkg::timer_t timeout_r, timeout_nxt;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;
  gbn_pkg::cmd_t   push_cmd;
  gbn_pkg::cmd_t   q_head;

  // timeout register; the user must write it only while the endpoint is idle, the block does not enforce this
  assign timeout_nxt = cfg_we ? cfg_wdata : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= gbn_pkg::TimeoutReset;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign busy = q_full;

  // front end: accept and classify
  gbn_front u_front (
    .start            (start),
    .q_full           (q_full),
    .in_op            (in_op),
    .in_payload       (in_payload),
    .in_frame_seq     (in_frame_seq),
    .in_frame_ack     (in_frame_ack),
    .in_frame_is_data (in_frame_is_data),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // decoupling queue
  gbn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // back end: window, timers and result generation
  gbn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .timeout     (timeout_r),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_seq     (out_seq),
    .out_ack     (out_ack),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the go-back-n arq endpoint
// depends on gbn_pkg and go_back_n_arq_endpoint; mirrors the window in a small class
// directed transactions first, then random phases under several timeout settings

module testbench;

  // op code with no meaning to the block, it must be ignored
  localparam logic [1:0] OpUnused = 2'd3;
  // cycles left for the back end to settle once the last result is in;
  // a transaction may give no result yet keep the back end walking slots
  localparam int HoldOff = 40;
  // cycles with neither an accepted transaction nor a result before giving up
  localparam int QuietLimit = 2000;
  localparam int RandomPerPhase = 55;

  // one transaction on the input side
  typedef struct {
    logic [1:0]        op;
    gbn_pkg::payload_t payload;
    gbn_pkg::seq_t     fseq;
    gbn_pkg::seq_t     fack;
    logic              is_data;
  } link_event_t;

  // one result as the block should present it
  typedef struct {
    gbn_pkg::kind_t    kind;
    gbn_pkg::seq_t     seq;
    gbn_pkg::seq_t     ack;
    gbn_pkg::payload_t payload;
    logic              last;
  } frame_result_t;

  // mirror of the sender window, the receiver position and the slot timers,
  // plus the queue of results still owed by the block
  class endpoint_model;
    gbn_pkg::timer_t   timeout;
    gbn_pkg::seq_t     next_seq;
    gbn_pkg::seq_t     oldest;
    gbn_pkg::seq_t     rx_seq;
    int                in_flight;
    gbn_pkg::payload_t slot_payload [gbn_pkg::SeqMod];
    gbn_pkg::timer_t   slot_age [gbn_pkg::SeqMod];
    bit                slot_live [gbn_pkg::SeqMod];
    frame_result_t     expected_frames [$];
    int                mismatches;

    function new();
      timeout   = gbn_pkg::TimeoutReset;
      next_seq  = '0;
      oldest    = '0;
      rx_seq    = '0;
      in_flight = 0;
      mismatches = 0;
      for (int i = 0; i < gbn_pkg::SeqMod; i++) begin
        slot_payload[i] = '0;
        slot_age[i]     = '0;
        slot_live[i]    = 1'b0;
      end
    endfunction

    function void push_frame(gbn_pkg::kind_t k, gbn_pkg::seq_t s, gbn_pkg::seq_t a,
                             gbn_pkg::payload_t p);
      frame_result_t r;
      r.kind    = k;
      r.seq     = s;
      r.ack     = a;
      r.payload = p;
      r.last    = 1'b0;
      expected_frames = {expected_frames, r};
    endfunction

    // data frame out of a slot; its timer starts again from zero
    function void emit_data_frame(gbn_pkg::seq_t slot);
      gbn_pkg::seq_t piggy;
      piggy = rx_seq - 1'b1;
      push_frame(gbn_pkg::KIND_DATA, slot, piggy, slot_payload[slot]);
      slot_age[slot]  = '0;
      slot_live[slot] = 1'b1;
    endfunction

    // accepted transaction: update the mirror and queue what it causes
    function void take_command(link_event_t c);
      int            before_n;
      int            i;
      bit            expired;
      gbn_pkg::seq_t ack_dist;
      before_n = expected_frames.size();
      case (c.op)
        gbn_pkg::OP_SEND: begin
          if (in_flight >= gbn_pkg::MaxSeq) begin
            push_frame(gbn_pkg::KIND_REFUSED, '0, '0, '0);
          end else begin
            slot_payload[next_seq] = c.payload;
            emit_data_frame(next_seq);
            in_flight++;
            next_seq = next_seq + 1'b1;
          end
        end
        gbn_pkg::OP_RECV: begin
          if (c.is_data && c.fseq == rx_seq) begin
            push_frame(gbn_pkg::KIND_DELIVER, '0, '0, c.payload);
            push_frame(gbn_pkg::KIND_ACK, '0, rx_seq, '0);
            rx_seq = rx_seq + 1'b1;
          end
          // cumulative release, up to and including the acked number
          ack_dist = c.fack - oldest;
          while (in_flight > 0 && int'(ack_dist) < in_flight) begin
            slot_live[oldest] = 1'b0;
            slot_age[oldest]  = '0;
            oldest = oldest + 1'b1;
            in_flight--;
            ack_dist = c.fack - oldest;
          end
        end
        gbn_pkg::OP_TICK: begin
          expired = 1'b0;
          for (i = 0; i < gbn_pkg::SeqMod; i++) begin
            if (slot_live[i]) begin
              if (slot_age[i] != gbn_pkg::TimerMax) slot_age[i]++;
              if (slot_age[i] >= timeout) expired = 1'b1;
            end
          end
          // go back: whole window again, oldest first
          if (expired) begin
            for (i = 0; i < in_flight; i++) emit_data_frame(oldest + gbn_pkg::seq_t'(i));
          end
        end
        default: ;
      endcase
      if (expected_frames.size() > before_n)
        expected_frames[expected_frames.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      if (mismatches < 50) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task match_result(logic [1:0] kind, gbn_pkg::seq_t seq, gbn_pkg::seq_t ack,
                      gbn_pkg::payload_t pay, logic last);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result with none owed: kind %0d seq %0d ack %0d pay %h",
                                  kind, seq, ack, pay));
        return;
      end
      want = expected_frames.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (seq !== want.seq)
        report_mismatch($sformatf("seq %0d, wanted %0d", seq, want.seq));
      if (ack !== want.ack)
        report_mismatch($sformatf("ack %0d, wanted %0d", ack, want.ack));
      if (pay !== want.payload)
        report_mismatch($sformatf("payload %h, wanted %h", pay, want.payload));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, wanted %b", last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_op = '0;
  gbn_pkg::payload_t in_payload = '0;
  gbn_pkg::seq_t     in_frame_seq = '0;
  gbn_pkg::seq_t     in_frame_ack = '0;
  logic              in_frame_is_data = 1'b0;
  logic              out_valid;
  logic [1:0]        out_kind;
  gbn_pkg::seq_t     out_seq;
  gbn_pkg::seq_t     out_ack;
  gbn_pkg::payload_t out_payload;
  logic              out_last;
  logic              cfg_we = 1'b0;
  gbn_pkg::timer_t   cfg_wdata = '0;

  endpoint_model model;
  int            quiet_cycles = 0;
  int            burst_left = 0;

  go_back_n_arq_endpoint u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_payload       (in_payload),
    .in_frame_seq     (in_frame_seq),
    .in_frame_ack     (in_frame_ack),
    .in_frame_is_data (in_frame_is_data),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_seq          (out_seq),
    .out_ack          (out_ack),
    .out_payload      (out_payload),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // results carry a one-cycle strobe and cannot be held off, so every
  // strobed cycle is checked at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid)
      model.match_result(out_kind, out_seq, out_ack, out_payload, out_last);
  end

  // watchdog: any accepted transaction or result counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic link_event_t make_event(logic [1:0] op, gbn_pkg::payload_t p,
                                             gbn_pkg::seq_t s, gbn_pkg::seq_t a,
                                             logic d);
    link_event_t e;
    e.op      = op;
    e.payload = p;
    e.fseq    = s;
    e.fack    = a;
    e.is_data = d;
    return e;
  endfunction

  // mostly a well-behaved peer: in-order data and acks inside the window,
  // with some out-of-order frames, stale acks and ignored op codes mixed in
  function automatic link_event_t random_event();
    link_event_t e;
    int          pick;
    pick      = $urandom_range(0, 99);
    e.payload = $urandom;
    e.fseq    = gbn_pkg::seq_t'($urandom_range(0, 7));
    e.fack    = gbn_pkg::seq_t'($urandom_range(0, 7));
    e.is_data = 1'($urandom_range(0, 1));
    if (pick < 35) begin
      e.op = gbn_pkg::OP_SEND;
    end else if (pick < 70) begin
      e.op      = gbn_pkg::OP_RECV;
      e.is_data = ($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 3) != 0) e.fseq = model.rx_seq;
      if (model.in_flight > 0 && $urandom_range(0, 9) < 7)
        e.fack = model.oldest + gbn_pkg::seq_t'($urandom_range(0, model.in_flight - 1));
    end else if (pick < 95) begin
      e.op = gbn_pkg::OP_TICK;
    end else begin
      e.op = OpUnused;
    end
    return e;
  endfunction

  // present one transaction after a random gap and hold it until taken;
  // start is left high so back-to-back transactions need no extra cycle
  task automatic issue_command(input link_event_t c);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
    end
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_op            <= c.op;
    in_payload       <= c.payload;
    in_frame_seq     <= c.fseq;
    in_frame_ack     <= c.fack;
    in_frame_is_data <= c.is_data;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.take_command(c);
  endtask

  // drop start, let every owed result arrive and the back end settle
  task automatic drain_block();
    @(negedge clk);
    start <= 1'b0;
    while (model.expected_frames.size() != 0) @(posedge clk);
    repeat (HoldOff) @(negedge clk);
  endtask

  // the timeout register is only touched while the block is quiet
  task automatic write_timeout(input gbn_pkg::timer_t value);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.timeout = value;
  endtask

  initial begin
    gbn_pkg::timer_t   phase_timeouts [6];
    gbn_pkg::payload_t send_words [7];
    model = new();
    send_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_0001, 32'h8000_0000, 32'h1234_5678};
    phase_timeouts = '{16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd6,
                       gbn_pkg::timer_t'($urandom_range(3, 15))};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset timeout
    // tick with an empty window, then an op code that means nothing
    issue_command(make_event(gbn_pkg::OP_TICK, '0, '0, '0, 1'b0));
    issue_command(make_event(OpUnused, '1, '1, '1, 1'b1));
    // fill the window, then one send too many is refused
    foreach (send_words[i])
      issue_command(make_event(gbn_pkg::OP_SEND, send_words[i], '0, '0, 1'b0));
    issue_command(make_event(gbn_pkg::OP_SEND, 32'hDEAD_BEEF, '0, '0, 1'b0));
    // pure ack whose number lies outside the window: nothing at all
    issue_command(make_event(gbn_pkg::OP_RECV, 32'h0F0F_0F0F, 3'd0, 3'd7, 1'b0));
    // out-of-order data: no delivery, but its ack still frees two slots
    issue_command(make_event(gbn_pkg::OP_RECV, 32'hFFFF_FFFF, 3'd3, 3'd1, 1'b1));
    // in-order data with a stale ack: delivered and acked only
    issue_command(make_event(gbn_pkg::OP_RECV, 32'hFFFF_FFFF, 3'd0, 3'd7, 1'b1));
    issue_command(make_event(gbn_pkg::OP_SEND, 32'hC0DE_0007, '0, '0, 1'b0));
    // zero timeout behaves like one: the next tick resends the lot
    write_timeout(16'd0);
    issue_command(make_event(gbn_pkg::OP_TICK, '0, '0, '0, 1'b0));
    issue_command(make_event(gbn_pkg::OP_RECV, 32'h7777_0001, 3'd1, 3'd7, 1'b1));
    issue_command(make_event(gbn_pkg::OP_TICK, '0, '0, '0, 1'b0));

    // random phases, each with its own timeout
    foreach (phase_timeouts[p]) begin
      write_timeout(phase_timeouts[p]);
      repeat (RandomPerPhase) issue_command(random_event());
    end

    drain_block();
    if (model.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
